// File: hw/rtl/sipf_pkg.sv
// Shared types and protocol constants for the servo instruction packet framer.
// No dependencies; imported by every module of the block.
`default_nettype none
package sipf_pkg;

	// command modes
	localparam logic [2:0] MODE_PING      = 3'd0;
	localparam logic [2:0] MODE_LIMIT     = 3'd1;
	localparam logic [2:0] MODE_POSITION  = 3'd2;
	localparam logic [2:0] MODE_REG_WRITE = 3'd3;
	localparam logic [2:0] MODE_ACTION    = 3'd4;
	localparam logic [2:0] MODE_SYNC_PAIR = 3'd5;

	// packet bytes
	localparam logic [7:0] HDR_BYTE       = 8'hFF;
	localparam logic [7:0] BROADCAST_ID   = 8'hFE;
	localparam logic [7:0] INS_PING       = 8'h01;
	localparam logic [7:0] INS_WRITE      = 8'h03;
	localparam logic [7:0] INS_REG_WRITE  = 8'h04;
	localparam logic [7:0] INS_ACTION     = 8'h05;
	localparam logic [7:0] INS_SYNC_WRITE = 8'h83;
	localparam logic [7:0] ADDR_LIMITS    = 8'h06;
	localparam logic [7:0] ADDR_GOAL      = 8'h1E;
	localparam logic [7:0] SYNC_DATA_LEN  = 8'h04;
	localparam logic [7:0] SYNC_LEN       = 8'h0E;
	localparam logic [7:0] WRITE_LEN      = 8'h07;
	localparam logic [7:0] SHORT_LEN      = 8'h02;

	localparam logic [15:0] CLAMP_RESET   = 16'd1023;

	// body = bytes between the two headers and the checksum
	localparam int BODY_MAX   = 15;
	localparam int BODY_LEN_W = 4;
	localparam int IDX_W      = 5;   // holds BODY_MAX + 2

	localparam logic [BODY_LEN_W-1:0] LEN_SHORT = 4'd3;
	localparam logic [BODY_LEN_W-1:0] LEN_WRITE = 4'd8;
	localparam logic [BODY_LEN_W-1:0] LEN_SYNC  = 4'd15;

	// command queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;

	typedef struct packed {
		logic [BODY_MAX-1:0][7:0] body;   // body[0] is sent first
		logic [BODY_LEN_W-1:0]    len;
	} desc_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage
`default_nettype wire

// File: hw/rtl/sipf_front.sv
// Front end: takes a command request, clamps values, builds the packet body.
// Depends on sipf_pkg; pushes descriptors into sipf_queue.
`default_nettype none
module sipf_front
	import sipf_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [15:0] clamp_limit,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  mode,
	input  wire logic [7:0]  servo_id,
	input  wire logic [15:0] first_value,
	input  wire logic [15:0] second_value,
	input  wire logic [7:0]  second_id,
	input  wire logic [15:0] third_value,
	input  wire logic [15:0] fourth_value,
	input  wire q_stat_t     q_stat,
	output logic             push,
	output desc_t            push_desc
);

	logic        valid_s1;
	logic [2:0]  mode_s1;
	logic [7:0]  id1_s1, id2_s1;
	logic [15:0] v1_s1, v2_s1, v3_s1, v4_s1;
	logic        clamp_en;
	logic [15:0] v1_sat, v2_sat;
	logic        drop;
	logic        stage_free;

	assign clamp_en = (mode == MODE_LIMIT) || (mode == MODE_POSITION);
	assign v1_sat   = (clamp_en && first_value > clamp_limit) ? clamp_limit : first_value;
	assign v2_sat   = (clamp_en && second_value > clamp_limit) ? clamp_limit : second_value;

	// unused modes are swallowed without a packet
	assign push       = valid_s1 && !drop && !q_stat.full;
	assign stage_free = !valid_s1 || drop || !q_stat.full;
	assign in_stall   = !stage_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stage_free) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stage_free && in_valid) begin
			mode_s1 <= mode;
			id1_s1  <= servo_id;
			id2_s1  <= second_id;
			v1_s1   <= v1_sat;
			v2_s1   <= v2_sat;
			v3_s1   <= third_value;
			v4_s1   <= fourth_value;
		end
	end

	always_comb begin
		push_desc = '0;
		drop      = 1'b0;
		case (mode_s1)
			MODE_PING: begin
				push_desc.body[0] = id1_s1;
				push_desc.body[1] = SHORT_LEN;
				push_desc.body[2] = INS_PING;
				push_desc.len     = LEN_SHORT;
			end
			MODE_LIMIT, MODE_POSITION, MODE_REG_WRITE: begin
				push_desc.body[0] = id1_s1;
				push_desc.body[1] = WRITE_LEN;
				push_desc.body[2] = (mode_s1 == MODE_REG_WRITE) ? INS_REG_WRITE : INS_WRITE;
				push_desc.body[3] = (mode_s1 == MODE_LIMIT) ? ADDR_LIMITS : ADDR_GOAL;
				push_desc.body[4] = v1_s1[7:0];
				push_desc.body[5] = v1_s1[15:8];
				push_desc.body[6] = v2_s1[7:0];
				push_desc.body[7] = v2_s1[15:8];
				push_desc.len     = LEN_WRITE;
			end
			MODE_ACTION: begin
				push_desc.body[0] = BROADCAST_ID;
				push_desc.body[1] = SHORT_LEN;
				push_desc.body[2] = INS_ACTION;
				push_desc.len     = LEN_SHORT;
			end
			MODE_SYNC_PAIR: begin
				push_desc.body[0]  = BROADCAST_ID;
				push_desc.body[1]  = SYNC_LEN;
				push_desc.body[2]  = INS_SYNC_WRITE;
				push_desc.body[3]  = ADDR_GOAL;
				push_desc.body[4]  = SYNC_DATA_LEN;
				push_desc.body[5]  = id1_s1;
				push_desc.body[6]  = v1_s1[7:0];
				push_desc.body[7]  = v1_s1[15:8];
				push_desc.body[8]  = v2_s1[7:0];
				push_desc.body[9]  = v2_s1[15:8];
				push_desc.body[10] = id2_s1;
				push_desc.body[11] = v3_s1[7:0];
				push_desc.body[12] = v3_s1[15:8];
				push_desc.body[13] = v4_s1[7:0];
				push_desc.body[14] = v4_s1[15:8];
				push_desc.len      = LEN_SYNC;
			end
			default: begin
				drop = 1'b1;
			end
		endcase
	end

endmodule
`default_nettype wire

// File: hw/rtl/sipf_queue.sv
// Short FIFO of packet descriptors between front end and serializer.
// Depends on sipf_pkg.
`default_nettype none
module sipf_queue
	import sipf_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire desc_t push_desc,
	input  wire logic  pop,
	output desc_t      pop_desc,
	output q_stat_t    q_stat
);

	desc_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;

	assign q_stat.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign q_stat.empty = (count_q == '0);
	assign pop_desc     = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_desc;
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/sipf_back.sv
// Serializer: sends headers, body bytes and running checksum, one per cycle while out_stall is low.
// Depends on sipf_pkg; pops descriptors from sipf_queue.
`default_nettype none
module sipf_back
	import sipf_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire q_stat_t q_stat,
	input  wire desc_t   pop_desc,
	output logic         pop,
	output logic         out_valid,
	input  wire logic    out_stall,
	output logic [7:0]   packet_byte,
	output logic         last_byte
);

	logic                     busy_q;
	logic [BODY_MAX-1:0][7:0] body_q;
	logic [BODY_LEN_W-1:0]    len_q;
	logic [IDX_W-1:0]         idx_q;
	logic [7:0]               sum_q;
	logic                     out_valid_q, last_byte_q;
	logic [7:0]               packet_byte_q;
	logic                     advance, emit, at_cs, in_hdr, can_load;
	logic [7:0]               next_byte;

	assign advance  = !out_valid_q || !out_stall;
	assign emit     = busy_q && advance;
	assign in_hdr   = (idx_q < IDX_W'(2));
	assign at_cs    = (idx_q == IDX_W'(len_q) + IDX_W'(2));
	assign can_load = !busy_q || (emit && at_cs);
	assign pop      = can_load && !q_stat.empty;

	always_comb begin
		if (in_hdr) begin
			next_byte = HDR_BYTE;
		end else if (at_cs) begin
			next_byte = ~sum_q;
		end else begin
			next_byte = body_q[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
			end else if (can_load) begin
				busy_q <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= busy_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			body_q <= pop_desc.body;
			len_q  <= pop_desc.len;
			idx_q  <= '0;
			sum_q  <= '0;
		end else if (emit) begin
			idx_q <= idx_q + 1'b1;
			if (!in_hdr && !at_cs) begin
				sum_q  <= sum_q + body_q[0];
				body_q <= {8'h00, body_q[BODY_MAX-1:1]};
			end
		end
		if (emit) begin
			packet_byte_q <= next_byte;
			last_byte_q   <= at_cs;
		end
	end

	assign out_valid   = out_valid_q;
	assign packet_byte = packet_byte_q;
	assign last_byte   = last_byte_q;

endmodule
`default_nettype wire

// File: hw/rtl/servo_instruction_packet_framer.sv
// Servo instruction packet framer, top level: clamp register, front end, queue, serializer.
// Depends on sipf_pkg, sipf_front, sipf_queue and sipf_back.
//
// Turns one servo command request into a protocol 1.0 instruction packet sent a byte
// per cycle: FF FF, id, length, instruction, parameters (16-bit values low byte first),
// then the inverted 8-bit sum of everything after the headers, flagged by last_byte.
// Ping and action give 6 bytes, limit/position/registered writes 11, a sync pair 18;
// modes 6 and 7 are accepted and produce nothing. Limit and position writes saturate
// both values at clamp_limit (reset 1023, written through cfg_wr_en/cfg_wr_data; the user
// is to write it only while the block is idle, which the block itself does not enforce).
// A request passes the front-end register, the two-entry descriptor queue and the
// serializer registers to the output byte register. The serializer sends one byte per
// cycle while out_stall is low and starts the next packet right after a checksum, so
// packets go back to back and requests are taken as fast as packets are sent. Up to
// three commands can be in flight (front register plus two queued) while a packet is sent,
// so the input side takes up to three more requests while the output stalls.
`default_nettype none
module servo_instruction_packet_framer
	import sipf_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [15:0] cfg_wr_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [2:0]  mode,
	input  wire logic [7:0]  servo_id,
	input  wire logic [15:0] first_value,
	input  wire logic [15:0] second_value,
	input  wire logic [7:0]  second_id,
	input  wire logic [15:0] third_value,
	input  wire logic [15:0] fourth_value,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       packet_byte,
	output logic             last_byte
);

	logic [15:0] clamp_limit_q;
	logic        push, pop;
	desc_t       push_desc, pop_desc;
	q_stat_t     q_stat;

	// saturation bound, the only configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clamp_limit_q <= CLAMP_RESET;
		end else if (cfg_wr_en) begin
			clamp_limit_q <= cfg_wr_data;
		end
	end

	// request intake, clamping and packet body assembly
	sipf_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.clamp_limit  (clamp_limit_q),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.servo_id     (servo_id),
		.first_value  (first_value),
		.second_value (second_value),
		.second_id    (second_id),
		.third_value  (third_value),
		.fourth_value (fourth_value),
		.q_stat       (q_stat),
		.push         (push),
		.push_desc    (push_desc)
	);

	// decouples intake from the byte stream
	sipf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.pop       (pop),
		.pop_desc  (pop_desc),
		.q_stat    (q_stat)
	);

	// byte serializer with running checksum and output register
	sipf_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_stat      (q_stat),
		.pop_desc    (pop_desc),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.packet_byte (packet_byte),
		.last_byte   (last_byte)
	);

endmodule
`default_nettype wire

// File: hw/rtl/sipf_checker.sv
// Port-level checks for the servo instruction packet framer, bound to the top level.
// Depends on sipf_pkg and servo_instruction_packet_framer.
`default_nettype none
module sipf_checker
	import sipf_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [7:0] packet_byte,
	input wire logic       last_byte
);

	logic [IDX_W-1:0] pos_q;   // position of the current byte within its packet
	logic             out_take;

	assign out_take = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (out_take) begin
			pos_q <= last_byte ? '0 : pos_q + 1'b1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(packet_byte) && $stable(last_byte))
		else $error("stalled output changed");

	a_headers: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pos_q < IDX_W'(2) |-> packet_byte == HDR_BYTE && !last_byte)
		else $error("packet does not open with two header bytes");

	a_length: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pos_q == IDX_W'(3) |->
			packet_byte == SHORT_LEN || packet_byte == WRITE_LEN || packet_byte == SYNC_LEN)
		else $error("bad length byte");

	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_byte |->
			pos_q == IDX_W'(5) || pos_q == IDX_W'(10) || pos_q == IDX_W'(17))
		else $error("packet ends at a wrong length");

endmodule

bind servo_instruction_packet_framer sipf_checker u_sipf_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.packet_byte (packet_byte),
	.last_byte   (last_byte)
);
`default_nettype wire
